// ===== rtl/cc20_pkg.sv =====
// Shared types, constants and round functions for the ChaCha20 keystream engine.
`default_nettype none

package cc20_pkg;

    localparam int DATA_W      = 64;
    localparam int CNT_W       = 4;
    localparam int CTR_W       = 32;
    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int KS_OFS_W    = 6;
    localparam int KEY_W       = 256;
    localparam int NONCE_W     = 96;

    localparam logic [3:0][31:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    // 16-word ChaCha state, word 0 in the low bits
    typedef logic [15:0][31:0] cc20_state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NONCE_W-1:0] nonce;
    } cc20_cfg_t;

    // One queued request: data plus where its keystream comes from
    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [CNT_W-1:0]    cnt;
        logic [KS_OFS_W-1:0] ofs;
        logic [CTR_W-1:0]    ctr;
        logic                need_new;
    } cc20_item_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } cc20_qr_t;

    function automatic cc20_qr_t cc20_quarter(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] a1, b1, c1, d1;
        cc20_qr_t r;
        a1 = a + b;  d1 = d ^ a1;  d1 = {d1[15:0], d1[31:16]};
        c1 = c + d1; b1 = b ^ c1;  b1 = {b1[19:0], b1[31:20]};
        a1 = a1 + b1; d1 = d1 ^ a1; d1 = {d1[23:0], d1[31:24]};
        c1 = c1 + d1; b1 = b1 ^ c1; b1 = {b1[24:0], b1[31:25]};
        r.a = a1;
        r.b = b1;
        r.c = c1;
        r.d = d1;
        return r;
    endfunction

    // Column round when diag is 0, diagonal round when diag is 1
    function automatic cc20_state_t cc20_round(input cc20_state_t s, input logic diag);
        cc20_state_t col, dia;
        cc20_qr_t q;
        col = s;
        dia = s;
        for (int i = 0; i < 4; i++) begin
            q = cc20_quarter(s[i], s[4 + i], s[8 + i], s[12 + i]);
            col[i] = q.a; col[4 + i] = q.b; col[8 + i] = q.c; col[12 + i] = q.d;
        end
        for (int i = 0; i < 4; i++) begin
            q = cc20_quarter(s[i], s[4 + ((i + 1) % 4)], s[8 + ((i + 2) % 4)],
                             s[12 + ((i + 3) % 4)]);
            dia[i] = q.a;
            dia[4 + ((i + 1) % 4)]  = q.b;
            dia[8 + ((i + 2) % 4)]  = q.c;
            dia[12 + ((i + 3) % 4)] = q.d;
        end
        return diag ? dia : col;
    endfunction

    function automatic cc20_state_t cc20_init(input cc20_cfg_t cfg, input logic [CTR_W-1:0] ctr);
        cc20_state_t s;
        for (int i = 0; i < 4; i++) s[i] = SIGMA[i];
        for (int i = 0; i < 8; i++) s[4 + i] = cfg.key[32 * i +: 32];
        s[12] = ctr;
        for (int i = 0; i < 3; i++) s[13 + i] = cfg.nonce[32 * i +: 32];
        return s;
    endfunction

    function automatic cc20_state_t cc20_sum(input cc20_state_t a, input cc20_state_t b);
        cc20_state_t s;
        for (int i = 0; i < 16; i++) s[i] = a[i] + b[i];
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cc20_keygen.sv =====
// Iterative keystream block generator: one full round per cycle, then the final add.
`default_nettype none

module cc20_keygen import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               abort,
    input  wire logic [CTR_W-1:0]   start_ctr,
    input  wire cc20_cfg_t          cfg,
    output logic                    busy,
    output logic                    done,
    output logic [CTR_W-1:0]        tag,
    output logic [BLOCK_W-1:0]      block
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W  = $clog2(ROUNDS);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } gen_state_t;

    gen_state_t           state_reg;
    logic [RND_W-1:0]     rnd_reg;
    logic [CTR_W-1:0]     tag_reg;
    cc20_state_t          work_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            tag_reg   <= '0;
            work_reg  <= '0;
        end else if (abort) begin
            state_reg <= ST_IDLE;
        end else if (start) begin
            // (re)load the input state for the requested counter
            state_reg <= ST_ROUND;
            rnd_reg   <= '0;
            tag_reg   <= start_ctr;
            work_reg  <= cc20_init(cfg, start_ctr);
        end else begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_ROUND: begin
                    work_reg <= cc20_round(work_reg, rnd_reg[0]);
                    if (rnd_reg == LAST_RND) begin
                        state_reg <= ST_FINAL;
                    end else begin
                        rnd_reg <= rnd_reg + RND_W'(1);
                    end
                end
                ST_FINAL: state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = (state_reg == ST_FINAL);
    assign tag   = tag_reg;
    assign block = cc20_sum(work_reg, cc20_init(cfg, tag_reg));

endmodule

`default_nettype wire

// ===== rtl/cc20_back.sv =====
// Back end: keystream block buffers, prefetch control, XOR and output register.
`default_nettype none

module cc20_back import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cc20_cfg_t          cfg,
    input  wire logic               cfg_write,
    input  wire logic               head_valid,
    input  wire cc20_item_t         head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DATA_W-1:0]       data_out,
    output logic [CNT_W-1:0]        out_count
);

    localparam int PAD_W = BLOCK_W + DATA_W;
    localparam int SEL_W = $clog2(PAD_W);

    logic                 gen_start, gen_busy, gen_done;
    logic [CTR_W-1:0]     gen_tag;
    logic [BLOCK_W-1:0]   gen_block;

    logic [BLOCK_W-1:0]   cur_blk_reg, spare_blk_reg;
    logic [CTR_W-1:0]     cur_tag_reg, spare_tag_reg;
    logic                 cur_valid_reg, spare_valid_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    data_out_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic                 need_blk, blk_hit, item_ok, out_free;
    logic                 want_valid, want_hit;
    logic [CTR_W-1:0]     want_tag;
    logic [BLOCK_W-1:0]   ks_src;
    logic [PAD_W-1:0]     ks_pad;
    logic [SEL_W-1:0]     ks_sel;
    logic [DATA_W-1:0]    ks_word;
    logic [DATA_W-1:0]    result;

    cc20_keygen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_keygen (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (gen_start),
        .abort     (cfg_write),
        .start_ctr (want_tag),
        .cfg       (cfg),
        .busy      (gen_busy),
        .done      (gen_done),
        .tag       (gen_tag),
        .block     (gen_block)
    );

    always_comb begin
        need_blk = head_valid && (head.cnt != '0) && head.need_new;
        blk_hit  = spare_valid_reg && (spare_tag_reg == head.ctr);
        item_ok  = !need_blk || blk_hit;
        out_free = !out_valid_reg || !out_stall;
        pop      = head_valid && item_ok && out_free;

        // fetch the block the head waits for, else run one block ahead
        want_valid = need_blk || cur_valid_reg;
        want_tag   = need_blk ? head.ctr : cur_tag_reg + CTR_W'(1);
        want_hit   = spare_valid_reg && (spare_tag_reg == want_tag);
        gen_start  = want_valid && !want_hit && !(gen_busy && (gen_tag == want_tag))
                     && !cfg_write;

        ks_src  = need_blk ? spare_blk_reg : cur_blk_reg;
        ks_pad  = {{DATA_W{1'b0}}, ks_src};
        ks_sel  = SEL_W'({head.ofs, 3'b000});
        ks_word = ks_pad[ks_sel +: DATA_W];
        for (int i = 0; i < DATA_W / 8; i++) begin
            result[8 * i +: 8] = (CNT_W'(i) < head.cnt)
                               ? (head.data[8 * i +: 8] ^ ks_word[8 * i +: 8]) : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            cur_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end
            if (pop && need_blk) begin
                cur_valid_reg <= 1'b1;
            end
            if (gen_done && !cfg_write) begin
                spare_valid_reg <= 1'b1;
            end else if (cfg_write || (pop && need_blk)) begin
                spare_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            data_out_reg  <= result;
            out_count_reg <= head.cnt;
        end
        if (pop && need_blk) begin
            cur_blk_reg <= spare_blk_reg;
            cur_tag_reg <= head.ctr;
        end
        if (gen_done && !cfg_write) begin
            spare_blk_reg <= gen_block;
            spare_tag_reg <= gen_tag;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

// ===== rtl/cc20_fifo.sv =====
// Short request queue between the front end and the back end.
`default_nettype none

module cc20_fifo import cc20_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cc20_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output cc20_item_t      head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cc20_item_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_QW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == CNT_QW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/cc20_front.sv =====
// Front end: accept requests, apply restarts, track word position and block counter.
`default_nettype none

module cc20_front import cc20_pkg::*; #(
    parameter int WORD_BYTES = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [DATA_W-1:0]  data_in,
    input  wire logic [CNT_W-1:0]   byte_count,
    input  wire logic               first,
    input  wire logic [CTR_W-1:0]   start_counter,
    input  wire logic               q_full,
    output logic                    q_push,
    output cc20_item_t              q_item
);

    localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
    localparam int WP_W        = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int LIMIT       = (WORD_BYTES < 8) ? WORD_BYTES : 8;
    localparam int OFS_FULL_W  = KS_OFS_W + 1;
    localparam logic [WP_W-1:0] LAST_WP = WP_W'(BLOCK_WORDS - 1);

    logic [WP_W-1:0]        wp_reg, wp_next, wp_v;
    logic [CTR_W-1:0]       ctr_reg, ctr_next, ctr_v;
    logic                   ready_reg, ready_next, ready_v;
    logic [CNT_W-1:0]       cnt;
    logic [OFS_FULL_W-1:0]  ofs_full;

    always_comb begin
        ctr_v   = ctr_reg;
        wp_v    = wp_reg;
        ready_v = ready_reg;
        if (first) begin
            ctr_v   = start_counter;
            wp_v    = '0;
            ready_v = 1'b0;
        end
        cnt      = (byte_count > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : byte_count;
        ofs_full = OFS_FULL_W'(wp_v) * OFS_FULL_W'(WORD_BYTES);

        q_item.data     = data_in;
        q_item.cnt      = cnt;
        q_item.ofs      = ofs_full[KS_OFS_W-1:0];
        q_item.ctr      = ctr_v;
        q_item.need_new = !ready_v;

        ctr_next   = ctr_v;
        wp_next    = wp_v;
        ready_next = ready_v;
        // an empty request consumes no keystream
        if (cnt != '0) begin
            if (wp_v == LAST_WP) begin
                wp_next    = '0;
                ctr_next   = ctr_v + CTR_W'(1);
                ready_next = 1'b0;
            end else begin
                wp_next    = wp_v + WP_W'(1);
                ready_next = 1'b1;
            end
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg    <= '0;
            ctr_reg   <= '0;
            ready_reg <= 1'b0;
        end else if (q_push) begin
            wp_reg    <= wp_next;
            ctr_reg   <= ctr_next;
            ready_reg <= ready_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
// Top level of the ChaCha20 stream cipher: register file, front end, queue, back end.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------
//  in      | in_valid / in_stall | data_in[63:0], byte_count[3:0], first
//  out     | out_valid/out_stall | data_out[63:0], out_count[3:0]
//  config  | APB psel/penable    | paddr[5:3] register, pwdata/prdata 64b
//
// A request inside a keystream block that is already held goes from the queue head
// through the XOR into the output register once that register is free. Keystream
// blocks come from one iterative generator that runs one full round per cycle and
// works one block ahead, so the sustained rate is the lower of one request per cycle,
// while the output does not stall, and the rate at which the generator makes blocks
// (64/WORD_BYTES requests each). A restart waits for its first block to be generated
// unless the block fetched ahead is the one it needs; a key change drops the block
// fetched ahead, so the next block boundary can wait for it to be generated again.
// Reset clears the registers, queue pointers and block valid flags; nothing needs
// a clearing pass. The input side stalls only when the queue is full; the output
// register lets the queue keep filling while a result waits.
`default_nettype none

module chacha20_stream_cipher import cc20_pkg::*; #(
    parameter int DOUBLE_ROUNDS = 10,
    parameter int WORD_BYTES    = 8,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [DATA_W-1:0]  data_in,
    input  wire logic [CNT_W-1:0]   byte_count,
    input  wire logic               first,
    // result output
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DATA_W-1:0]       data_out,
    output logic [CNT_W-1:0]        out_count,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCE0 = 3'd4,
        REG_NONCE1 = 3'd5,
        REG_START  = 3'd6
    } cfg_reg_t;

    logic [63:0]        key0_reg, key1_reg, key2_reg, key3_reg, nonce0_reg;
    logic [31:0]        nonce1_reg, start_reg;
    cfg_reg_t           reg_sel;
    logic               cfg_write;
    cc20_cfg_t          cfg;

    logic               q_push, q_full, q_pop, q_head_valid;
    cc20_item_t         q_item, q_head;

    assign pready    = 1'b1;
    assign reg_sel   = cfg_reg_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write; an address past the last register is dropped.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            nonce0_reg <= '0;
            nonce1_reg <= '0;
            start_reg  <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_KEY0:   key0_reg   <= pwdata;
                REG_KEY1:   key1_reg   <= pwdata;
                REG_KEY2:   key2_reg   <= pwdata;
                REG_KEY3:   key3_reg   <= pwdata;
                REG_NONCE0: nonce0_reg <= pwdata;
                REG_NONCE1: nonce1_reg <= pwdata[31:0];
                REG_START:  start_reg  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KEY0:   prdata = key0_reg;
            REG_KEY1:   prdata = key1_reg;
            REG_KEY2:   prdata = key2_reg;
            REG_KEY3:   prdata = key3_reg;
            REG_NONCE0: prdata = nonce0_reg;
            REG_NONCE1: prdata = {32'h0, nonce1_reg};
            REG_START:  prdata = {32'h0, start_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.key   = {key3_reg, key2_reg, key1_reg, key0_reg};
    assign cfg.nonce = {nonce1_reg, nonce0_reg};

    // Front end: restarts, byte count limit, block counter and word position.
    cc20_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_in       (data_in),
        .byte_count    (byte_count),
        .first         (first),
        .start_counter (start_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    // Queue: decouples request intake from keystream availability.
    cc20_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back end: block generation, prefetch and XOR into the output register.
    cc20_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_write  (cfg_write),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .out_count  (out_count)
    );

endmodule

`default_nettype wire
